[hdl/tsp_pkg.sv]
// Package for the two-electrode touch slider block.
// Holds command codes, register indexes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package tsp_pkg;

    // command codes (tuser of the input word)
    localparam logic [1:0] CMD_CAL  = 2'd0;
    localparam logic [1:0] CMD_SCAN = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_THR_FIRST  = 2'd0;
    localparam logic [1:0] REG_THR_SECOND = 2'd1;
    localparam logic [1:0] REG_CH_FIRST   = 2'd2;
    localparam logic [1:0] REG_CH_SECOND  = 2'd3;

    localparam int CNT_W   = 16;   // raw count / baseline
    localparam int DELTA_W = 15;   // clamped delta
    localparam int CH_W    = 4;    // channel number
    localparam int POS_W   = 7;    // position 0..100
    localparam int QUO_W   = 7;    // quotient bits of d*100/sum
    localparam int DVD_W   = 23;   // dividend / shifted divisor width

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [DELTA_W-1:0] THR_RESET       = 15'd100;
    localparam logic [CH_W-1:0]    CH_FIRST_RESET  = 4'd9;
    localparam logic [CH_W-1:0]    CH_SECOND_RESET = 4'd8;

    localparam logic [8:0] FULL_SCALE = 9'd100;
    localparam logic [POS_W-1:0] POS_MAX = 7'd100;

endpackage

[hdl/touch_slider_position.sv]
// Top level of the two-electrode touch slider position block.
// Command decode, per-electrode state and a shared shift-subtract divider.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input stream s_axis: one command word per handshake. tuser carries the
//   command (calibrate, scan, read); tdata carries electrode and raw count.
//   Output stream m_axis: exactly one result word per command, holding the
//   position, the channel to scan next and the round-complete flag.
//   Configuration: i_cfg_wr_en writes register i_cfg_idx with i_cfg_data
//   (thresholds and channel numbers); write only while the block is idle.
// Timing:
//   Calibrate, scan and reads that start no division (round not complete,
//   no touch or zero delta sum): the result word is registered on the
//   accepting edge and offered the next cycle, so these commands can follow
//   one per cycle while m_axis_tready is high.
//   A read that finds a touch at round end runs two divisions of delta*100
//   by the delta sum on one restoring divider, 7 steps each, plus load and
//   finish states; the word is registered when the second division ends.
//   s_axis_tready is low while busy.
// Reset: synchronous, active low. Thresholds go to 100, channels to 9 and 8,
//   baselines, deltas, electrode pointer and round flag to zero.
// Stall: the result waits in the output register until m_axis_tready; no
//   new command is taken while it is held.
module touch_slider_position (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [0] electrode, [16:1] count, zero fill
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] position, [10:7] scan_channel,
                                        // [11] round_complete, zero fill
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    // configuration
    logic [tsp_pkg::DELTA_W-1:0] r_thr [2];
    logic [tsp_pkg::CH_W-1:0]    r_ch  [2];

    // slider state
    logic [tsp_pkg::CNT_W-1:0]   r_base  [2];
    logic [tsp_pkg::DELTA_W-1:0] r_delta [2];
    logic r_cur, n_cur;
    logic r_done, n_done;

    // sequencer and divider
    logic [2:0]                  r_state, n_state;
    logic                        r_phase, n_phase;
    logic [2:0]                  r_step, n_step;
    logic [tsp_pkg::DVD_W-1:0]   r_rem, n_rem;
    logic [tsp_pkg::DVD_W-1:0]   r_div, n_div;
    logic [tsp_pkg::QUO_W-1:0]   r_quo, n_quo;
    logic [tsp_pkg::QUO_W-1:0]   r_a, n_a;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [tsp_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                        w_accept;
    logic [1:0]                  w_cmd;
    logic                        w_elec;
    logic [tsp_pkg::CNT_W-1:0]   w_count;
    logic [tsp_pkg::CNT_W-1:0]   w_diff;
    logic [tsp_pkg::DELTA_W-1:0] w_new_delta;
    logic [tsp_pkg::CNT_W-1:0]   w_sum;
    logic                        w_touch;
    logic [tsp_pkg::DELTA_W-1:0] w_op;
    logic [tsp_pkg::DVD_W-1:0]   w_op_ext;
    logic [tsp_pkg::DVD_W-1:0]   w_dividend;
    logic [8:0]                  w_pos9;
    logic                        w_delta_we;

    assign w_cmd   = s_axis_tuser;
    assign w_elec  = s_axis_tdata[0];
    assign w_count = s_axis_tdata[16:1];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_diff      = w_count - r_base[r_cur];
    assign w_new_delta = w_diff[15] ? '0 : w_diff[14:0];
    assign w_sum       = {1'b0, r_delta[0]} + {1'b0, r_delta[1]};
    assign w_touch     = (r_delta[0] > r_thr[0]) || (r_delta[1] > r_thr[1]);

    // d*100 = d*64 + d*32 + d*4
    assign w_op       = r_phase ? r_delta[1] : r_delta[0];
    assign w_op_ext   = {{(tsp_pkg::DVD_W-tsp_pkg::DELTA_W){1'b0}}, w_op};
    assign w_dividend = (w_op_ext << 6) + (w_op_ext << 5) + (w_op_ext << 2);

    assign w_pos9 = tsp_pkg::FULL_SCALE - {2'b00, r_a} + {2'b00, r_quo};

    assign w_delta_we = w_accept && (w_cmd == tsp_pkg::CMD_SCAN) && !r_done;

    always_comb begin
        logic [tsp_pkg::POS_W-1:0] pos;
        logic                      emit;
        n_state     = r_state;
        n_phase     = r_phase;
        n_step      = r_step;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_a         = r_a;
        n_cur       = r_cur;
        n_done      = r_done;
        pos         = '0;
        emit        = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    emit = 1'b1;
                    priority if (w_cmd == tsp_pkg::CMD_SCAN) begin
                        if (!r_done) begin
                            n_cur  = !r_cur;
                            n_done = r_cur;
                        end
                    end else if (w_cmd == tsp_pkg::CMD_READ) begin
                        if (r_done) begin
                            if (w_touch && (w_sum != '0)) begin
                                emit    = 1'b0;
                                n_state = S_LOAD;
                                n_phase = 1'b0;
                            end else begin
                                n_done = 1'b0;
                            end
                        end
                    end else begin
                    end
                end
            end
            S_LOAD: begin
                n_rem   = w_dividend;
                n_div   = {1'b0, w_sum, 6'b0};
                n_quo   = '0;
                n_step  = 3'd6;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_rem >= r_div) begin
                    n_rem = r_rem - r_div;
                    n_quo = {r_quo[tsp_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[tsp_pkg::QUO_W-2:0], 1'b0};
                end
                n_div  = r_div >> 1;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_phase) begin
                    n_a     = r_quo;
                    n_phase = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    pos     = w_pos9[7:1];
                    n_done  = 1'b0;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_data = r_out_data;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_data  = {4'b0, n_done, (n_cur ? r_ch[1] : r_ch[0]), pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_cur       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr[0]    <= tsp_pkg::THR_RESET;
            r_thr[1]    <= tsp_pkg::THR_RESET;
            r_ch[0]     <= tsp_pkg::CH_FIRST_RESET;
            r_ch[1]     <= tsp_pkg::CH_SECOND_RESET;
            r_base[0]   <= '0;
            r_base[1]   <= '0;
            r_delta[0]  <= '0;
            r_delta[1]  <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    tsp_pkg::REG_THR_FIRST:  r_thr[0] <= i_cfg_data;
                    tsp_pkg::REG_THR_SECOND: r_thr[1] <= i_cfg_data;
                    tsp_pkg::REG_CH_FIRST:   r_ch[0]  <= i_cfg_data[3:0];
                    tsp_pkg::REG_CH_SECOND:  r_ch[1]  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_accept && (w_cmd == tsp_pkg::CMD_CAL)) begin
                r_base[w_elec] <= w_count;
            end
            if (w_delta_we) begin
                r_delta[r_cur] <= w_new_delta;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_a        <= n_a;
        r_out_data <= n_out_data;
    end

endmodule

[hdl/tsp_checker.sv]
// Port-level checker for touch_slider_position, attached by bind.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // position never exceeds full scale
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= tsp_pkg::POS_MAX))
        else $error("position out of range");

    // a reported position always comes with the round flag cleared
    a_pos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6:0] != '0) |-> !m_axis_tdata[11])
        else $error("position reported with round still complete");

    // no new command while a result word is stalled
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("command taken while result stalled");

endmodule

bind touch_slider_position tsp_checker u_tsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
